// ===== src/ipv4dr_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4dr_pkg
// Shared types and constants for the IPv4 destination rewrite block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dr_pkg;

	localparam int MAX_HEADER_WORDS = 30;
	localparam int MIN_HEADER_WORDS = 10;
	localparam int CKSUM_WORD       = 5;
	localparam int DST_HI_WORD      = 8;
	localparam int DST_LO_WORD      = 9;

	localparam int WORD_W = 16;
	localparam int CNT_W  = $clog2(MAX_HEADER_WORDS + 1);
	localparam int ADDR_W = $clog2(MAX_HEADER_WORDS);
	localparam int SUM_W  = 21;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 2;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_NEW_DEST = 2'd0;

	typedef struct packed {
		logic [WORD_W-1:0] in_word;
		logic              in_last;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_word;
		logic              out_last;
		logic              malformed;
	} out_item_t;

endpackage

`default_nettype wire

// ===== src/ipv4dr_ram.sv =====
// ----------------------------------------------------------------------------
// ipv4dr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 30
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ipv4dr_cfg.sv =====
// ----------------------------------------------------------------------------
// ipv4dr_cfg
// APB register file holding the replacement destination address.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dr_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipv4dr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ipv4dr_pkg::DATA_W-1:0]   pwdata,
	output logic      [ipv4dr_pkg::DATA_W-1:0]   prdata,
	output logic                                 pready,
	output logic      [ipv4dr_pkg::DATA_W-1:0]   new_dest
);

	import ipv4dr_pkg::*;

	logic [DATA_W-1:0] dest_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr == REG_NEW_DEST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q <= '0;
		end else if (wr_en) begin
			dest_q <= pwdata;
		end
	end

	always_comb begin
		case (paddr)
			REG_NEW_DEST: prdata = dest_q;
			default:      prdata = '0;
		endcase
	end

	assign new_dest = dest_q;

endmodule

`default_nettype wire

// ===== src/ipv4_dest_rewrite_checksum.sv =====
// ----------------------------------------------------------------------------
// ipv4_dest_rewrite_checksum
// IPv4 header destination rewrite with Internet checksum regeneration.
// ----------------------------------------------------------------------------
// Header words are taken one per cycle while busy is low and written into a
// 30-entry header RAM. The transfer with in_last high closes the header;
// busy then stays high through a checksum state and an emit state that reads
// one stored word per cycle, the rate set by the single read port of the
// header RAM. Results leave on consecutive cycles, each valid for one cycle
// under strobe, the first one once the checksum state and the registered RAM
// read have passed. The receiver cannot stall. The next header may start in
// the cycle that shows the last result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dest_rewrite_checksum (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire ipv4dr_pkg::in_item_t            in_item,
	output logic                                 strobe,
	output ipv4dr_pkg::out_item_t                result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipv4dr_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ipv4dr_pkg::DATA_W-1:0]   pwdata,
	output logic      [ipv4dr_pkg::DATA_W-1:0]   prdata,
	output logic                                 pready
);

	import ipv4dr_pkg::*;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ovf_q;
	logic              bad_q;
	logic [WORD_W-1:0] cks_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] idx_s1;

	logic [DATA_W-1:0] new_dest;
	logic [WORD_W-1:0] dst_hi, dst_lo;
	logic              accept, room, skip_sum;
	logic [CNT_W-1:0]  n_next;
	logic              ram_we, ram_re;
	logic [WORD_W-1:0] ram_rdata;
	logic [SUM_W+1:0]  full_sum;
	logic [WORD_W:0]   fold1;
	logic [WORD_W-1:0] fold2;

	ipv4dr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.new_dest (new_dest)
	);

	assign dst_hi = new_dest[DATA_W-1:WORD_W];
	assign dst_lo = new_dest[WORD_W-1:0];

	assign busy   = (state_q != ST_LOAD);
	assign accept = start & ~busy;
	assign room   = (count_q < CNT_W'(MAX_HEADER_WORDS));
	assign n_next = room ? count_q + CNT_W'(1) : count_q;
	// checksum and destination words are left out of the running sum
	assign skip_sum = (count_q == CNT_W'(CKSUM_WORD)) || (count_q == CNT_W'(DST_HI_WORD)) ||
		(count_q == CNT_W'(DST_LO_WORD));

	assign ram_we = accept & room;
	assign ram_re = (state_q == ST_EMIT);

	ipv4dr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_HEADER_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (in_item.in_word),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// add in the new address halves where present, then fold twice
	always_comb begin
		full_sum = {2'b00, sum_q};
		if (n_q > CNT_W'(DST_HI_WORD)) begin
			full_sum = full_sum + (SUM_W+2)'(dst_hi);
		end
		if (n_q > CNT_W'(DST_LO_WORD)) begin
			full_sum = full_sum + (SUM_W+2)'(dst_lo);
		end
		fold1 = (WORD_W+1)'(full_sum[SUM_W+1:WORD_W]) + {1'b0, full_sum[WORD_W-1:0]};
		fold2 = fold1[WORD_W-1:0] + WORD_W'(fold1[WORD_W]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			n_q      <= '0;
			sum_q    <= '0;
			ovf_q    <= 1'b0;
			bad_q    <= 1'b0;
			cks_q    <= '0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			valid_s1 <= ram_re;
			idx_s1   <= rd_idx_q;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= n_next;
							if (!skip_sum) begin
								sum_q <= sum_q + SUM_W'(in_item.in_word);
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_item.in_last) begin
							n_q     <= n_next;
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					cks_q    <= ~fold2;
					bad_q    <= ovf_q || (n_q < CNT_W'(MIN_HEADER_WORDS));
					count_q  <= '0;
					sum_q    <= '0;
					ovf_q    <= 1'b0;
					rd_idx_q <= '0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					rd_idx_q <= rd_idx_q + ADDR_W'(1);
					if (CNT_W'(rd_idx_q) + CNT_W'(1) == n_q) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// rewritten fields are substituted on the way out of the RAM
	always_comb begin
		result.out_last  = (CNT_W'(idx_s1) + CNT_W'(1) == n_q);
		result.malformed = bad_q;
		if (idx_s1 == ADDR_W'(CKSUM_WORD)) begin
			result.out_word = cks_q;
		end else if (idx_s1 == ADDR_W'(DST_HI_WORD)) begin
			result.out_word = dst_hi;
		end else if (idx_s1 == ADDR_W'(DST_LO_WORD)) begin
			result.out_word = dst_lo;
		end else begin
			result.out_word = ram_rdata;
		end
	end

	assign strobe = valid_s1;

endmodule

`default_nettype wire
